// File: sv/xdn_pkg.sv
// Shared types and constants of the X-drive wheel mix and normalize unit.
// Used by xdn_front, xdn_div_step and the top level; depends on nothing.
package xdn_pkg;

  // Field widths
  localparam int unsigned InW    = 16;  // body velocity components
  localparam int unsigned TgtW   = 15;  // target speed register
  localparam int unsigned WheelW = 18;  // signed wheel speed
  localparam int unsigned MagW   = 17;  // wheel magnitude, up to 98304
  localparam int unsigned ProdW  = MagW + TgtW;  // magnitude times target
  localparam int unsigned QuoW   = TgtW;  // scaled wheel never exceeds target
  localparam int unsigned Lanes  = 4;

  // Lane order matches the output word
  localparam int unsigned LaneFl = 0;
  localparam int unsigned LaneFr = 1;
  localparam int unsigned LaneRl = 2;
  localparam int unsigned LaneRr = 3;

  // Pipeline shape: three front stages, one divide stage per quotient bit,
  // one output stage
  localparam int unsigned FrontStages = 3;
  localparam int unsigned DivStages   = QuoW;
  localparam int unsigned NumStages   = FrontStages + DivStages + 1;

  // Word that moves through the divider stages. acc holds the partial
  // remainder in the top MagW bits and the not yet consumed dividend bits
  // (shifting out) plus the quotient bits (shifting in) in the low QuoW bits.
  typedef struct packed {
    logic [Lanes-1:0][WheelW-1:0] raw;
    logic [Lanes-1:0][ProdW-1:0]  acc;
    logic [MagW-1:0]              divisor;
    logic                         scale;
  } div_word_t;

endpackage

// File: sv/x_drive_wheel_mix_normalize_unit.sv
// Top level of the X-drive wheel mix and normalize unit.
// Instantiates xdn_front and xdn_div_step; depends on xdn_pkg.
//
// Usage:
//   s_axis carries one velocity command per word: tdata holds x, y and turn
//   speed (16 bit signed each), tuser holds the normalize flag.
//   m_axis returns one word of four 18 bit signed wheel speeds per command.
//   cfg writes target_speed; its ready is always high. Write it only while
//   no command is in flight.
// Pipeline: mix, max, multiply, fifteen divide steps of one quotient bit
//   each, output register.
// Throughput: one command per cycle unless m_axis stalls; every stage holds its own word.
// Stall: a stage only holds when the stage after it holds, so bubbles
//   collapse and the input keeps taking words while a result waits, until
//   the pipeline is full. Nothing is lost or repeated.
// Reset: all valid bits clear, target_speed returns to zero.
module x_drive_wheel_mix_normalize_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Command stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // x_speed[15:0], y_speed[31:16], turn_speed[47:32]
  input  logic        s_axis_tuser,   // normalize[0]
  // Wheel speed stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata,   // front_left[17:0], front_right[35:18],
                                      // rear_left[53:36], rear_right[71:54]
  // Target speed register
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [14:0] cfg_data_i
);

  localparam int unsigned NS = xdn_pkg::NumStages;
  localparam int unsigned FS = xdn_pkg::FrontStages;
  localparam int unsigned DS = xdn_pkg::DivStages;
  localparam int unsigned WW = xdn_pkg::WheelW;
  localparam int unsigned QW = xdn_pkg::QuoW;
  localparam int unsigned NL = xdn_pkg::Lanes;
  localparam int unsigned IW = xdn_pkg::InW;

  // Target speed register
  logic [xdn_pkg::TgtW-1:0] target_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q <= '0;
    end else if (cfg_valid_i) begin
      target_q <= cfg_data_i;
    end
  end

  // Valid bits and per-stage advance
  logic [NS-1:0] valid_q, valid_d;
  logic [NS-1:0] en;

  always_comb begin
    en[NS-1] = !valid_q[NS-1] || m_axis_tready;
    for (int i = NS - 2; i >= 0; i--) begin
      en[i] = !valid_q[i] || en[i+1];
    end
    valid_d[0] = en[0] ? s_axis_tvalid : valid_q[0];
    for (int i = 1; i < NS; i++) begin
      valid_d[i] = en[i] ? valid_q[i-1] : valid_q[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign s_axis_tready = en[0];
  assign m_axis_tvalid = valid_q[NS-1];

  // Mix, max and multiply
  xdn_pkg::div_word_t div_word [DS+1];

  xdn_front u_front (
    .clk_i         (clk_i),
    .en_i          (en[FS-1:0]),
    .x_speed_i     (s_axis_tdata[IW-1:0]),
    .y_speed_i     (s_axis_tdata[2*IW-1:IW]),
    .turn_speed_i  (s_axis_tdata[3*IW-1:2*IW]),
    .normalize_i   (s_axis_tuser),
    .target_speed_i(target_q),
    .word_o        (div_word[0])
  );

  // Divider chain, one quotient bit per stage
  for (genvar g = 0; g < DS; g++) begin : g_div
    xdn_div_step u_step (
      .clk_i (clk_i),
      .en_i  (en[FS+g]),
      .word_i(div_word[g]),
      .word_o(div_word[g+1])
    );
  end

  // Output stage: apply sign to quotient or pass the raw mix
  logic [NL-1:0][WW-1:0] out_d, out_q;
  logic [WW-1:0] quo_ext;

  always_comb begin
    quo_ext = '0;
    for (int i = 0; i < NL; i++) begin
      quo_ext = WW'(div_word[DS].acc[i][QW-1:0]);
      if (div_word[DS].scale) begin
        out_d[i] = div_word[DS].raw[i][WW-1] ? -quo_ext : quo_ext;
      end else begin
        out_d[i] = div_word[DS].raw[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[NS-1]) begin
      out_q <= out_d;
    end
  end

  assign m_axis_tdata = out_q;

endmodule

// File: sv/xdn_front.sv
// Front end of the wheel mixer: mix, magnitude and max, then scale multiply.
// Three register stages; depends on xdn_pkg.
module xdn_front (
  input  logic                          clk_i,
  input  logic [xdn_pkg::FrontStages-1:0] en_i,
  input  logic signed [xdn_pkg::InW-1:0] x_speed_i,
  input  logic signed [xdn_pkg::InW-1:0] y_speed_i,
  input  logic signed [xdn_pkg::InW-1:0] turn_speed_i,
  input  logic                          normalize_i,
  input  logic [xdn_pkg::TgtW-1:0]      target_speed_i,
  output xdn_pkg::div_word_t            word_o
);

  localparam int unsigned WW = xdn_pkg::WheelW;
  localparam int unsigned MW = xdn_pkg::MagW;
  localparam int unsigned NL = xdn_pkg::Lanes;

  // Stage 0: wheel mix
  logic signed [WW-1:0] x_ext, y_ext, r_ext;
  logic [NL-1:0][WW-1:0] mix_d, mix_q;
  logic norm0_q;

  always_comb begin
    x_ext = WW'(x_speed_i);
    y_ext = WW'(y_speed_i);
    r_ext = WW'(turn_speed_i);
    mix_d[xdn_pkg::LaneFl] = y_ext + x_ext + r_ext;
    mix_d[xdn_pkg::LaneFr] = y_ext - x_ext - r_ext;
    mix_d[xdn_pkg::LaneRl] = y_ext - x_ext + r_ext;
    mix_d[xdn_pkg::LaneRr] = y_ext + x_ext - r_ext;
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      mix_q   <= mix_d;
      norm0_q <= normalize_i;
    end
  end

  // Stage 1: magnitudes and largest magnitude
  logic [NL-1:0][MW-1:0] mag_d, mag_q;
  logic [MW-1:0] max_a, max_b, max_d, max_q;
  logic [NL-1:0][WW-1:0] raw1_q;
  logic norm1_q;
  logic [WW-1:0] neg_tmp;

  always_comb begin
    neg_tmp = '0;
    for (int i = 0; i < NL; i++) begin
      neg_tmp  = -mix_q[i];
      mag_d[i] = mix_q[i][WW-1] ? neg_tmp[MW-1:0] : mix_q[i][MW-1:0];
    end
    max_a = (mag_d[0] > mag_d[1]) ? mag_d[0] : mag_d[1];
    max_b = (mag_d[2] > mag_d[3]) ? mag_d[2] : mag_d[3];
    max_d = (max_a > max_b) ? max_a : max_b;
  end

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      mag_q   <= mag_d;
      max_q   <= max_d;
      raw1_q  <= mix_q;
      norm1_q <= norm0_q;
    end
  end

  // Stage 2: magnitude times target, the dividend of each lane
  xdn_pkg::div_word_t word_d, word_q;

  always_comb begin
    word_d.raw     = raw1_q;
    word_d.divisor = max_q;
    word_d.scale   = norm1_q && (max_q != '0);
    for (int i = 0; i < NL; i++) begin
      word_d.acc[i] = mag_q[i] * target_speed_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      word_q <= word_d;
    end
  end

  assign word_o = word_q;

endmodule

// File: sv/xdn_div_step.sv
// One restoring division step for all four lanes, one quotient bit each.
// Registered output; depends on xdn_pkg.
module xdn_div_step (
  input  logic               clk_i,
  input  logic               en_i,
  input  xdn_pkg::div_word_t word_i,
  output xdn_pkg::div_word_t word_o
);

  localparam int unsigned MW = xdn_pkg::MagW;
  localparam int unsigned QW = xdn_pkg::QuoW;
  localparam int unsigned NL = xdn_pkg::Lanes;

  xdn_pkg::div_word_t word_d, word_q;
  logic [MW:0] trial;
  logic [MW:0] diff;
  logic        ge;

  // Shift in the next dividend bit, subtract the divisor when it fits
  always_comb begin
    word_d = word_i;
    trial  = '0;
    diff   = '0;
    ge     = 1'b0;
    for (int i = 0; i < NL; i++) begin
      trial = {word_i.acc[i][MW+QW-1:QW], word_i.acc[i][QW-1]};
      diff  = trial - {1'b0, word_i.divisor};
      ge    = trial >= {1'b0, word_i.divisor};
      word_d.acc[i] = {(ge ? diff[MW-1:0] : trial[MW-1:0]), word_i.acc[i][QW-2:0], ge};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      word_q <= word_d;
    end
  end

  assign word_o = word_q;

endmodule

// File: tb/sv/x_drive_wheel_mix_normalize_unit_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for the X-drive wheel mix and normalize unit: a directed table, then
// random velocity words under fixed and random target speeds, checked against a wheel predictor.
// Depends on xdn_pkg and x_drive_wheel_mix_normalize_unit.
module x_drive_wheel_mix_normalize_unit_tb;

  localparam int unsigned CycleLimit = 300000;
  localparam int unsigned DrainWait  = 30;   // pipeline is 19 deep

  // One velocity word as it travels on s_axis
  typedef struct packed {
    logic              normalize;
    logic signed [15:0] turn_speed;
    logic signed [15:0] y_speed;
    logic signed [15:0] x_speed;
  } velocity_cmd_t;

  // Four wheel speeds, lane 0 (front left) in the low bits as on m_axis
  typedef logic [xdn_pkg::Lanes-1:0][xdn_pkg::WheelW-1:0] wheel_set_t;

  // Directed row: target to run under, command, and a typed answer where obvious
  typedef struct packed {
    logic [xdn_pkg::TgtW-1:0] target;
    velocity_cmd_t            cmd;
    logic                     typed;
    wheel_set_t               typed_wheels;
  } speed_row_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata  = '0;  // x_speed[15:0], y_speed[31:16], turn_speed[47:32]
  logic        s_axis_tuser  = 1'b0;  // normalize[0]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [71:0] m_axis_tdata;  // front_left[17:0], front_right[35:18],
                              // rear_left[53:36], rear_right[71:54]
  logic        cfg_valid_i   = 1'b0;
  logic        cfg_ready_o;
  logic [14:0] cfg_data_i    = '0;

  logic [xdn_pkg::TgtW-1:0] target_model = '0;
  wheel_set_t      expected_wheels [$];
  speed_row_t      speed_rows [$];
  int unsigned     mismatch_count = 0;
  int unsigned     cycle_count    = 0;
  int unsigned     burst_left     = 0;
  string           lane_names [xdn_pkg::Lanes] =
    '{"front_left", "front_right", "rear_left", "rear_right"};

  x_drive_wheel_mix_normalize_unit u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  always #6 clk_i = ~clk_i;

  // Wheel predictor: X-drive mix, then optional scale of the largest wheel to target
  function automatic wheel_set_t mix_wheels(input velocity_cmd_t c,
                                            input logic [xdn_pkg::TgtW-1:0] tgt);
    int signed       w [xdn_pkg::Lanes];
    int signed       xs, ys, rs;
    longint unsigned peak, mag, q;
    wheel_set_t      res;
    xs = c.x_speed;
    ys = c.y_speed;
    rs = c.turn_speed;
    w[xdn_pkg::LaneFl] = ys + xs + rs;
    w[xdn_pkg::LaneFr] = ys - xs - rs;
    w[xdn_pkg::LaneRl] = ys - xs + rs;
    w[xdn_pkg::LaneRr] = ys + xs - rs;
    peak = 0;
    for (int i = 0; i < xdn_pkg::Lanes; i++) begin
      mag = (w[i] < 0) ? -w[i] : w[i];
      if (mag > peak) peak = mag;
    end
    // all-zero wheels pass through even with normalize set
    for (int i = 0; i < xdn_pkg::Lanes; i++) begin
      if (c.normalize && peak != 0) begin
        mag = (w[i] < 0) ? -w[i] : w[i];
        q = (mag * tgt) / peak;  // truncates toward zero on the magnitude
        w[i] = (w[i] < 0) ? -int'(q) : int'(q);
      end
      res[i] = xdn_pkg::WheelW'(w[i]);
    end
    return res;
  endfunction

  function automatic velocity_cmd_t make_cmd(input int x, input int y, input int r, input bit norm);
    velocity_cmd_t c;
    c.x_speed    = 16'(x);
    c.y_speed    = 16'(y);
    c.turn_speed = 16'(r);
    c.normalize  = norm;
    return c;
  endfunction

  function automatic void add_row(input int tgt, input int x, input int y, input int r,
                                  input bit norm, input bit typed,
                                  input int fl, input int fr, input int rl, input int rr);
    speed_row_t row;
    row.target          = xdn_pkg::TgtW'(tgt);
    row.cmd             = make_cmd(x, y, r, norm);
    row.typed           = typed;
    row.typed_wheels[xdn_pkg::LaneFl] = xdn_pkg::WheelW'(fl);
    row.typed_wheels[xdn_pkg::LaneFr] = xdn_pkg::WheelW'(fr);
    row.typed_wheels[xdn_pkg::LaneRl] = xdn_pkg::WheelW'(rl);
    row.typed_wheels[xdn_pkg::LaneRr] = xdn_pkg::WheelW'(rr);
    speed_rows.push_back(row);
  endfunction

  // Mostly full-range, with small values and the extremes mixed in
  function automatic int rand_speed();
    case ($urandom_range(0, 5))
      0, 1, 5: return int'($signed(16'($urandom)));
      2:       return int'($urandom_range(0, 16)) - 8;
      3: begin
        case ($urandom_range(0, 3))
          0: return 32767;
          1: return -32768;
          2: return 0;
          default: return -1;
        endcase
      end
      default: return int'($urandom_range(0, 1023)) - 512;
    endcase
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] wheel check: %s", $realtime, msg);
    mismatch_count++;
  endtask

  // Sender gap: drop valid and put junk on the data lines
  task automatic idle_cycles(input int unsigned n);
    if (n > 0) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= 48'({$urandom, $urandom});
      s_axis_tuser  <= 1'($urandom_range(0, 1));
      repeat (n) @(posedge clk_i);
    end
  endtask

  // Bursts of random length separated by random gaps
  task automatic pace_sender();
    if (burst_left == 0) begin
      idle_cycles($urandom_range(0, 7));
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
  endtask

  task automatic send_cmd(input velocity_cmd_t c, input wheel_set_t want);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {c.turn_speed, c.y_speed, c.x_speed};
    s_axis_tuser  <= c.normalize;
    do @(posedge clk_i); while (!s_axis_tready);
    expected_wheels.push_back(want);
  endtask

  // Hold off until every expected word has come back
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    while (expected_wheels.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_target(input logic [xdn_pkg::TgtW-1:0] value);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    target_model = value;
  endtask

  // Result checker and receiver stall pattern
  always @(posedge clk_i) begin
    wheel_set_t got, want;
    int unsigned mode_cnt;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      if (expected_wheels.size() == 0) begin
        report_mismatch($sformatf("unexpected word %h", got));
      end else begin
        want = expected_wheels.pop_front();
        for (int i = 0; i < xdn_pkg::Lanes; i++) begin
          if (got[i] !== want[i])
            report_mismatch($sformatf("%s got %0d expected %0d", lane_names[i],
                                      int'($signed(got[i])), int'($signed(want[i]))));
        end
      end
    end
    // stall mode rotates in turn: open, random, periodic, long stalls
    mode_cnt = cycle_count % 388;
    if (mode_cnt < 97)       m_axis_tready <= 1'b1;
    else if (mode_cnt < 194) m_axis_tready <= ($urandom_range(0, 3) != 0);
    else if (mode_cnt < 291) m_axis_tready <= (cycle_count % 5 == 1) || (cycle_count % 7 == 0);
    else                     m_axis_tready <= (cycle_count % 24) >= 18;
  end

  // Cycle limit
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    speed_row_t    row;
    velocity_cmd_t c;
    wheel_set_t    want;
    logic [xdn_pkg::TgtW-1:0] phase_targets [6];

    // Reset-value target of zero
    add_row(0, 0, 0, 0, 1'b0, 1'b1, 0, 0, 0, 0);
    add_row(0, 0, 0, 0, 1'b1, 1'b1, 0, 0, 0, 0);          // all wheels zero
    add_row(0, 1, 0, 0, 1'b1, 1'b1, 0, 0, 0, 0);          // target zero
    add_row(0, 32767, 32767, 32767, 1'b0, 1'b1, 98301, -32767, 32767, 32767);
    add_row(0, -32768, -32768, -32768, 1'b0, 1'b1, -98304, 32768, -32768, -32768);
    // Full-scale target
    add_row(32767, 0, 0, 0, 1'b1, 1'b1, 0, 0, 0, 0);
    add_row(32767, 0, 100, 0, 1'b1, 1'b1, 32767, 32767, 32767, 32767);
    add_row(32767, 100, 0, 0, 1'b1, 1'b1, 32767, -32767, -32767, 32767);
    add_row(32767, 0, 0, -5, 1'b1, 1'b1, -32767, 32767, -32767, 32767);
    add_row(32767, 32767, 32767, 32767, 1'b1, 1'b0, 0, 0, 0, 0);
    add_row(32767, -32768, -32768, -32768, 1'b1, 1'b0, 0, 0, 0, 0);
    add_row(32767, 32767, -32768, -32768, 1'b0, 1'b0, 0, 0, 0, 0);
    add_row(32767, 1, 2, 3, 1'b1, 1'b0, 0, 0, 0, 0);
    // Smallest non-zero target
    add_row(1, 3, 0, 0, 1'b1, 1'b1, 1, -1, -1, 1);
    add_row(1, 1, 1, 1, 1'b1, 1'b0, 0, 0, 0, 0);
    add_row(1, -32768, 32767, -1, 1'b1, 1'b0, 0, 0, 0, 0);
    // Mid-range target
    add_row(12345, -32768, 32767, 0, 1'b1, 1'b0, 0, 0, 0, 0);
    add_row(12345, 7, -3, 11, 1'b1, 1'b0, 0, 0, 0, 0);
    add_row(12345, -21845, 10922, 5461, 1'b0, 1'b0, 0, 0, 0, 0);

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table
    foreach (speed_rows[i]) begin
      row = speed_rows[i];
      if (row.target != target_model) write_target(row.target);
      pace_sender();
      want = row.typed ? row.typed_wheels : mix_wheels(row.cmd, target_model);
      send_cmd(row.cmd, want);
    end

    // Random phases, each under its own target
    phase_targets[0] = xdn_pkg::TgtW'($urandom_range(2, 32766));
    phase_targets[1] = xdn_pkg::TgtW'(32767);
    phase_targets[2] = xdn_pkg::TgtW'(0);
    phase_targets[3] = xdn_pkg::TgtW'(1);
    phase_targets[4] = xdn_pkg::TgtW'($urandom_range(0, 255));
    phase_targets[5] = xdn_pkg::TgtW'($urandom);
    foreach (phase_targets[p]) begin
      write_target(phase_targets[p]);
      repeat (84) begin
        pace_sender();
        if ($urandom_range(0, 99) == 0) drain();
        c = make_cmd(rand_speed(), rand_speed(), rand_speed(), $urandom_range(0, 3) != 0);
        send_cmd(c, mix_wheels(c, target_model));
      end
    end

    drain();
    repeat (DrainWait) @(posedge clk_i);
    if (mismatch_count == 0 && expected_wheels.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
